### design/tun_pkg.sv
// Shared constants for the triangle unit normal pipeline.
`timescale 1ns / 1ps
package tun_pkg;
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int NORM_FRAC_BITS_DEF = 14;
    localparam int NUM_AXES           = 3;
    localparam int FRONT_STAGES       = 6;
endpackage

### design/tun_if.sv
// Valid/ready channel interfaces for triangle words and normal words.
`timescale 1ns / 1ps
interface tun_in_if
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] vert_a_x;
    logic [COORD_WIDTH-1:0] vert_a_y;
    logic [COORD_WIDTH-1:0] vert_a_z;
    logic [COORD_WIDTH-1:0] vert_b_x;
    logic [COORD_WIDTH-1:0] vert_b_y;
    logic [COORD_WIDTH-1:0] vert_b_z;
    logic [COORD_WIDTH-1:0] vert_c_x;
    logic [COORD_WIDTH-1:0] vert_c_y;
    logic [COORD_WIDTH-1:0] vert_c_z;

    modport source (output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                    vert_b_z, vert_c_x, vert_c_y, vert_c_z, input ready);
    modport sink (input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
                  vert_b_z, vert_c_x, vert_c_y, vert_c_z, output ready);
endinterface

interface tun_out_if
    import tun_pkg::*;
#(
    parameter int NORM_WIDTH = NORM_FRAC_BITS_DEF + 2
) ();
    logic                         valid;
    logic                         ready;
    logic signed [NORM_WIDTH-1:0] norm_x;
    logic signed [NORM_WIDTH-1:0] norm_y;
    logic signed [NORM_WIDTH-1:0] norm_z;
    logic                         degenerate;

    modport source (output valid, norm_x, norm_y, norm_z, degenerate, input ready);
    modport sink (input valid, norm_x, norm_y, norm_z, degenerate, output ready);
endinterface

### design/tun_front.sv
// Front pipeline: edges, cross product, squared length and scaled numerators.
`timescale 1ns / 1ps
module tun_front
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF,
    localparam int EW = COORD_WIDTH + 1,
    localparam int PW = 2 * EW,
    localparam int MW = 2 * EW,
    localparam int SW = 4 * EW,
    localparam int XW = SW + 2 * NORM_FRAC_BITS + 6
)
(
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] en,
    input  logic [COORD_WIDTH-1:0]  va [NUM_AXES],
    input  logic [COORD_WIDTH-1:0]  vb [NUM_AXES],
    input  logic [COORD_WIDTH-1:0]  vc [NUM_AXES],
    output logic [SW-1:0]           s_out,
    output logic [XW-1:0]           x_out [NUM_AXES],
    output logic                    neg_out [NUM_AXES],
    output logic                    deg_out
);
    logic signed [EW-1:0] e1_reg [NUM_AXES];
    logic signed [EW-1:0] e2_reg [NUM_AXES];
    logic signed [PW-1:0] p_reg [2*NUM_AXES];
    logic signed [PW:0]   n_next [NUM_AXES];
    logic [MW-1:0]        mag_reg [NUM_AXES];
    logic [MW-1:0]        mag_next [NUM_AXES];
    logic [MW-1:0]        hh_reg [NUM_AXES];
    logic [MW-1:0]        hl_reg [NUM_AXES];
    logic [MW-1:0]        ll_reg [NUM_AXES];
    logic [SW-1:0]        sq_reg [NUM_AXES];
    logic [SW-1:0]        s_next;
    logic [SW-1:0]        s_reg;
    logic [XW-1:0]        x_reg [NUM_AXES];
    logic                 deg_reg;
    logic                 neg3_reg [NUM_AXES];
    logic                 neg4_reg [NUM_AXES];
    logic                 neg5_reg [NUM_AXES];
    logic                 neg6_reg [NUM_AXES];

    // stage 1: edge vectors
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                e1_reg[i] <= EW'($signed(vb[i])) - EW'($signed(va[i]));
                e2_reg[i] <= EW'($signed(vc[i])) - EW'($signed(va[i]));
            end
        end
    end

    // stage 2: six cross-product terms
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg[0] <= PW'(e1_reg[1]) * PW'(e2_reg[2]);
            p_reg[1] <= PW'(e2_reg[1]) * PW'(e1_reg[2]);
            p_reg[2] <= PW'(e2_reg[0]) * PW'(e1_reg[2]);
            p_reg[3] <= PW'(e1_reg[0]) * PW'(e2_reg[2]);
            p_reg[4] <= PW'(e1_reg[0]) * PW'(e2_reg[1]);
            p_reg[5] <= PW'(e2_reg[0]) * PW'(e1_reg[1]);
        end
    end

    // stage 3: components as sign and magnitude
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            n_next[i]   = (PW+1)'(p_reg[2*i]) - (PW+1)'(p_reg[2*i+1]);
            mag_next[i] = n_next[i][PW] ? MW'(-n_next[i]) : MW'(n_next[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                mag_reg[i]  <= mag_next[i];
                neg3_reg[i] <= n_next[i][PW];
            end
        end
    end

    // stage 4: square in halves to keep each multiplier narrow
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                hh_reg[i]   <= MW'(mag_reg[i][MW-1:EW]) * MW'(mag_reg[i][MW-1:EW]);
                hl_reg[i]   <= MW'(mag_reg[i][MW-1:EW]) * MW'(mag_reg[i][EW-1:0]);
                ll_reg[i]   <= MW'(mag_reg[i][EW-1:0]) * MW'(mag_reg[i][EW-1:0]);
                neg4_reg[i] <= neg3_reg[i];
            end
        end
    end

    // stage 5: recombine partial products
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sq_reg[i]   <= (SW'(hh_reg[i]) << (2 * EW)) + (SW'(hl_reg[i]) << (EW + 1))
                               + SW'(ll_reg[i]);
                neg5_reg[i] <= neg4_reg[i];
            end
        end
    end

    // stage 6: squared length and numerators n^2 * 4^(F+1)
    assign s_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s_reg   <= s_next;
            deg_reg <= (s_next == '0);
            for (int i = 0; i < NUM_AXES; i++)
            begin
                x_reg[i]    <= XW'(sq_reg[i]) << (2 * NORM_FRAC_BITS + 2);
                neg6_reg[i] <= neg5_reg[i];
            end
        end
    end

    assign s_out   = s_reg;
    assign x_out   = x_reg;
    assign neg_out = neg6_reg;
    assign deg_out = deg_reg;
endmodule

### design/tun_root_step.sv
// One digit of the rounded quotient n * 2^F / sqrt(s), for all three axes.
`timescale 1ns / 1ps
module tun_root_step
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF,
    parameter int STEP_BIT       = NORM_FRAC_BITS_DEF,
    localparam int EW = COORD_WIDTH + 1,
    localparam int SW = 4 * EW,
    localparam int XW = SW + 2 * NORM_FRAC_BITS + 6,
    localparam int YW = SW + NORM_FRAC_BITS + 2,
    localparam int QW = NORM_FRAC_BITS + 1
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [SW-1:0] s_in,
    input  logic [XW-1:0] x_in [NUM_AXES],
    input  logic [YW-1:0] y_in [NUM_AXES],
    input  logic [QW-1:0] q_in [NUM_AXES],
    input  logic          neg_in [NUM_AXES],
    input  logic          deg_in,
    output logic [SW-1:0] s_out,
    output logic [XW-1:0] x_out [NUM_AXES],
    output logic [YW-1:0] y_out [NUM_AXES],
    output logic [QW-1:0] q_out [NUM_AXES],
    output logic          neg_out [NUM_AXES],
    output logic          deg_out
);
    // x = R - v^2*s, y = v*s with v = 2q; trial tests (v+d-1)^2*s <= R, d = 2^(b+1)
    logic [XW-1:0] xa [NUM_AXES];
    logic [XW-1:0] trial [NUM_AXES];
    logic          take [NUM_AXES];
    logic [SW-1:0] s_reg;
    logic [XW-1:0] x_reg [NUM_AXES];
    logic [YW-1:0] y_reg [NUM_AXES];
    logic [QW-1:0] q_reg [NUM_AXES];
    logic          neg_reg [NUM_AXES];
    logic          deg_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            xa[i]    = x_in[i] - (XW'(y_in[i]) << (STEP_BIT + 2))
                       - (XW'(s_in) << (2 * STEP_BIT + 2));
            trial[i] = xa[i] + (XW'(y_in[i]) << 1) + (XW'(s_in) << (STEP_BIT + 2))
                       - XW'(s_in);
            // once q reaches 2^F every larger candidate is out of range
            take[i]  = !trial[i][XW-1] && !q_in[i][QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_in;
            deg_reg <= deg_in;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                neg_reg[i] <= neg_in[i];
                x_reg[i]   <= take[i] ? xa[i] : x_in[i];
                y_reg[i]   <= take[i] ? y_in[i] + (YW'(s_in) << (STEP_BIT + 1)) : y_in[i];
                q_reg[i]   <= take[i] ? q_in[i] | (QW'(1) << STEP_BIT) : q_in[i];
            end
        end
    end

    assign s_out   = s_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign q_out   = q_reg;
    assign neg_out = neg_reg;
    assign deg_out = deg_reg;
endmodule

### design/triangle_unit_normal.sv
// Top level: unit surface normal of a triangle, fully pipelined.
//
// tri_in carries one triangle word (three vertices, signed Q12.4); norm_out
// carries one normal word (three signed Q1.F components, rounded to nearest,
// ties away from zero) plus a degenerate flag. Both are valid/ready channels;
// a word moves on a clock edge where valid and ready are both high.
// The pipeline is six front stages (edges, cross product, split squaring,
// sums), one stage per quotient bit, and the output register. One triangle
// is taken every cycle unless the pipeline is full and norm_out is stalled.
// Each stage holds its word while the stage after it is full and stalled, and
// an empty stage always loads, so bubbles close up and tri_in.ready stays high
// until every stage holds a word and norm_out is stalled.
// A zero cross product gives a zero normal with degenerate set.
// Reset empties the pipeline (all valid bits clear); no words are lost or
// duplicated when the receiver drops ready.
`timescale 1ns / 1ps
module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int NORM_FRAC_BITS = NORM_FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    tun_in_if.sink    tri_in,
    tun_out_if.source norm_out
);
    localparam int EW    = COORD_WIDTH + 1;
    localparam int SW    = 4 * EW;
    localparam int XW    = SW + 2 * NORM_FRAC_BITS + 6;
    localparam int YW    = SW + NORM_FRAC_BITS + 2;
    localparam int QW    = NORM_FRAC_BITS + 1;
    localparam int OW    = NORM_FRAC_BITS + 2;
    localparam int NSTEP = NORM_FRAC_BITS + 1;
    localparam int DEPTH = FRONT_STAGES + NSTEP + 1;

    logic [COORD_WIDTH-1:0] va [NUM_AXES];
    logic [COORD_WIDTH-1:0] vb [NUM_AXES];
    logic [COORD_WIDTH-1:0] vc [NUM_AXES];

    logic [SW-1:0] s_st   [NSTEP+1];
    logic [XW-1:0] x_st   [NSTEP+1][NUM_AXES];
    logic [YW-1:0] y_st   [NSTEP+1][NUM_AXES];
    logic [QW-1:0] q_st   [NSTEP+1][NUM_AXES];
    logic          neg_st [NSTEP+1][NUM_AXES];
    logic          deg_st [NSTEP+1];

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_in;
    logic [DEPTH:0]   en;

    logic signed [OW-1:0] norm_reg [NUM_AXES];
    logic signed [OW-1:0] norm_next [NUM_AXES];
    logic                 deg_reg;

    assign va[0] = tri_in.vert_a_x;
    assign va[1] = tri_in.vert_a_y;
    assign va[2] = tri_in.vert_a_z;
    assign vb[0] = tri_in.vert_b_x;
    assign vb[1] = tri_in.vert_b_y;
    assign vb[2] = tri_in.vert_b_z;
    assign vc[0] = tri_in.vert_c_x;
    assign vc[1] = tri_in.vert_c_y;
    assign vc[2] = tri_in.vert_c_z;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        en[DEPTH] = norm_out.ready;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_in = {valid_reg[DEPTH-2:0], tri_in.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    assign tri_in.ready = en[0];

    tun_front #(
        .COORD_WIDTH    (COORD_WIDTH),
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .en      (en[FRONT_STAGES-1:0]),
        .va      (va),
        .vb      (vb),
        .vc      (vc),
        .s_out   (s_st[0]),
        .x_out   (x_st[0]),
        .neg_out (neg_st[0]),
        .deg_out (deg_st[0])
    );

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            y_st[0][i] = '0;
            q_st[0][i] = '0;
        end
    end

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        tun_root_step #(
            .COORD_WIDTH    (COORD_WIDTH),
            .NORM_FRAC_BITS (NORM_FRAC_BITS),
            .STEP_BIT       (NORM_FRAC_BITS - j)
        ) u_step (
            .clk     (clk),
            .en      (en[FRONT_STAGES+j]),
            .s_in    (s_st[j]),
            .x_in    (x_st[j]),
            .y_in    (y_st[j]),
            .q_in    (q_st[j]),
            .neg_in  (neg_st[j]),
            .deg_in  (deg_st[j]),
            .s_out   (s_st[j+1]),
            .x_out   (x_st[j+1]),
            .y_out   (y_st[j+1]),
            .q_out   (q_st[j+1]),
            .neg_out (neg_st[j+1]),
            .deg_out (deg_st[j+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (deg_st[NSTEP])
            begin
                norm_next[i] = '0;
            end
            else if (neg_st[NSTEP][i])
            begin
                norm_next[i] = -$signed(OW'(q_st[NSTEP][i]));
            end
            else
            begin
                norm_next[i] = $signed(OW'(q_st[NSTEP][i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DEPTH-1])
        begin
            norm_reg <= norm_next;
            deg_reg  <= deg_st[NSTEP];
        end
    end

    assign norm_out.valid      = valid_reg[DEPTH-1];
    assign norm_out.norm_x     = norm_reg[0];
    assign norm_out.norm_y     = norm_reg[1];
    assign norm_out.norm_z     = norm_reg[2];
    assign norm_out.degenerate = deg_reg;

`ifndef ASSERT_OFF
    localparam logic signed [OW-1:0] NORM_ONE = OW'(1) << NORM_FRAC_BITS;

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid && norm_out.degenerate |->
            norm_out.norm_x == '0 && norm_out.norm_y == '0 && norm_out.norm_z == '0)
        else $error("degenerate word with nonzero normal");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        norm_out.valid |->
            norm_out.norm_x <= NORM_ONE && norm_out.norm_x >= -NORM_ONE &&
            norm_out.norm_y <= NORM_ONE && norm_out.norm_y >= -NORM_ONE &&
            norm_out.norm_z <= NORM_ONE && norm_out.norm_z >= -NORM_ONE)
        else $error("normal component beyond unit range");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !tri_in.ready |-> norm_out.valid && !norm_out.ready && (&valid_reg))
        else $error("input held off while pipeline has room");
`endif
endmodule
